### rtl/stt_pkg.sv
// Package with the shared types, token codes and character helpers of the tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  // Saturation limits of the position and length counters.
  localparam logic [15:0] MAX_LINE         = 16'hFFFF;
  localparam logic [15:0] MAX_COLUMN       = 16'hFFFF;
  localparam logic [7:0]  MAX_TOKEN_LENGTH = 8'hFF;

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_EQ     = 3'd3;
  localparam logic [2:0] MODE_BANG   = 3'd4;
  localparam logic [2:0] MODE_LT     = 3'd5;
  localparam logic [2:0] MODE_GT     = 3'd6;

  // Token kinds.
  localparam logic [4:0] KIND_IDENT    = 5'd0;
  localparam logic [4:0] KIND_INT      = 5'd1;
  localparam logic [4:0] KIND_ASSIGN   = 5'd2;
  localparam logic [4:0] KIND_SEMI     = 5'd4;
  localparam logic [4:0] KIND_COLON    = 5'd5;
  localparam logic [4:0] KIND_COMMA    = 5'd6;
  localparam logic [4:0] KIND_DOT      = 5'd7;
  localparam logic [4:0] KIND_LPAREN   = 5'd8;
  localparam logic [4:0] KIND_RPAREN   = 5'd9;
  localparam logic [4:0] KIND_LBRACE   = 5'd10;
  localparam logic [4:0] KIND_RBRACE   = 5'd11;
  localparam logic [4:0] KIND_LBRACKET = 5'd12;
  localparam logic [4:0] KIND_RBRACKET = 5'd13;
  localparam logic [4:0] KIND_PLUS     = 5'd14;
  localparam logic [4:0] KIND_MINUS    = 5'd15;
  localparam logic [4:0] KIND_STAR     = 5'd16;
  localparam logic [4:0] KIND_SLASH    = 5'd17;
  localparam logic [4:0] KIND_BANG     = 5'd18;
  localparam logic [4:0] KIND_LT       = 5'd20;
  localparam logic [4:0] KIND_GT       = 5'd22;
  localparam logic [4:0] KIND_ILLEGAL  = 5'd24;
  localparam logic [4:0] KIND_END      = 5'd25;

  // One input transaction.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  token_length;
    logic [7:0]  illegal_byte;
    logic        last_of_run;
  } out_t;

  // Results produced by one byte, in order: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

  // Kind of a single-character token; the top bit flags a match.
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] r;
    r = 6'd0;
    unique case (b)
      ";":     r = {1'b1, KIND_SEMI};
      ":":     r = {1'b1, KIND_COLON};
      ",":     r = {1'b1, KIND_COMMA};
      ".":     r = {1'b1, KIND_DOT};
      "(":     r = {1'b1, KIND_LPAREN};
      ")":     r = {1'b1, KIND_RPAREN};
      "{":     r = {1'b1, KIND_LBRACE};
      "}":     r = {1'b1, KIND_RBRACE};
      "[":     r = {1'b1, KIND_LBRACKET};
      "]":     r = {1'b1, KIND_RBRACKET};
      "+":     r = {1'b1, KIND_PLUS};
      "-":     r = {1'b1, KIND_MINUS};
      "*":     r = {1'b1, KIND_STAR};
      "/":     r = {1'b1, KIND_SLASH};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Single-character kind of a pending operator mode.
  function automatic logic [4:0] op_kind(input logic [2:0] mode);
    logic [4:0] k;
    k = KIND_GT;
    unique case (mode)
      MODE_EQ:   k = KIND_ASSIGN;
      MODE_BANG: k = KIND_BANG;
      MODE_LT:   k = KIND_LT;
      default:   k = KIND_GT;
    endcase
    return k;
  endfunction

endpackage

### rtl/stt_scan.sv
// Scanner: holds the lexer state and turns one byte into up to two tokens.
`timescale 1ns / 1ps

module stt_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  stt_pkg::in_t  in_i,
  output stt_pkg::push_t push_o
);

  logic [2:0]  mode_q, mode_d;
  logic [15:0] tok_line_q, tok_line_d;
  logic [15:0] tok_col_q, tok_col_d;
  logic [7:0]  plen_q, plen_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;

  logic [7:0]  b;
  logic        eoi;
  logic        is_ws;
  logic [5:0]  sk;
  logic        b_letter;
  logic        b_digit;
  logic [2:0]  begin_mode;
  logic        idle_emit;
  stt_pkg::out_t idle_res;
  logic        flush_emit;
  stt_pkg::out_t flush_res;
  logic        pending_tok;
  logic        pending_op;

  assign b        = in_i.char_byte;
  assign eoi      = in_i.end_of_input || (b == 8'd0);
  assign is_ws    = (b == " ") || (b == "\t") || (b == "\n") || (b == "\r");
  assign sk       = stt_pkg::single_kind(b);
  assign b_letter = stt_pkg::is_letter(b);
  assign b_digit  = stt_pkg::is_digit(b);
  assign pending_tok = (mode_q == stt_pkg::MODE_IDENT) || (mode_q == stt_pkg::MODE_NUMBER);
  assign pending_op  = (mode_q >= stt_pkg::MODE_EQ) && (mode_q <= stt_pkg::MODE_GT);

  // Classify the byte as if no token were pending.
  always_comb begin
    begin_mode = stt_pkg::MODE_IDLE;
    idle_emit  = 1'b0;
    idle_res   = '0;
    idle_res.start_line   = line_q;
    idle_res.start_column = col_q;
    idle_res.token_length = 8'd1;
    priority if (is_ws) begin
      idle_emit = 1'b0;
    end else if (sk[5]) begin
      idle_emit = 1'b1;
      idle_res.token_kind = sk[4:0];
    end else if (b == "=") begin
      begin_mode = stt_pkg::MODE_EQ;
    end else if (b == "!") begin
      begin_mode = stt_pkg::MODE_BANG;
    end else if (b == "<") begin
      begin_mode = stt_pkg::MODE_LT;
    end else if (b == ">") begin
      begin_mode = stt_pkg::MODE_GT;
    end else if (b_letter) begin
      begin_mode = stt_pkg::MODE_IDENT;
    end else if (b_digit) begin
      begin_mode = stt_pkg::MODE_NUMBER;
    end else begin
      idle_emit = 1'b1;
      idle_res.token_kind   = stt_pkg::KIND_ILLEGAL;
      idle_res.illegal_byte = b;
    end
  end

  // The pending token as it stands, closed without extension.
  always_comb begin
    flush_emit = pending_tok || pending_op;
    flush_res  = '0;
    flush_res.start_line   = tok_line_q;
    flush_res.start_column = tok_col_q;
    flush_res.token_length = plen_q;
    if (mode_q == stt_pkg::MODE_IDENT) begin
      flush_res.token_kind = stt_pkg::KIND_IDENT;
    end else if (mode_q == stt_pkg::MODE_NUMBER) begin
      flush_res.token_kind = stt_pkg::KIND_INT;
    end else begin
      flush_res.token_kind = stt_pkg::op_kind(mode_q);
    end
  end

  // Next state and the ordered results of this byte.
  always_comb begin
    stt_pkg::out_t r0, r1;
    logic v0, v1;
    mode_d     = mode_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    plen_d     = plen_q;
    line_d     = line_q;
    col_d      = col_q;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = flush_res;
    r1 = idle_res;

    if (eoi) begin
      // Flush, then the end token; the state returns to its reset value.
      r1 = '0;
      r1.token_kind   = stt_pkg::KIND_END;
      r1.start_line   = line_q;
      r1.start_column = col_q;
      v0 = flush_emit;
      v1 = 1'b1;
      mode_d     = stt_pkg::MODE_IDLE;
      tok_line_d = 16'd0;
      tok_col_d  = 16'd0;
      plen_d     = 8'd0;
      line_d     = 16'd1;
      col_d      = 16'd1;
    end else begin
      if (pending_tok && (b_digit || (mode_q == stt_pkg::MODE_IDENT && b_letter))) begin
        // Extend the identifier or integer.
        if (plen_q != stt_pkg::MAX_TOKEN_LENGTH) begin
          plen_d = plen_q + 8'd1;
        end
      end else if (pending_op && b == "=") begin
        // Two-character operator.
        r0.token_kind   = flush_res.token_kind + 5'd1;
        r0.token_length = 8'd2;
        v0 = 1'b1;
        mode_d = stt_pkg::MODE_IDLE;
      end else begin
        // Close what is pending and scan the byte fresh.
        v0 = flush_emit;
        v1 = idle_emit;
        mode_d = begin_mode;
        if (begin_mode != stt_pkg::MODE_IDLE) begin
          tok_line_d = line_q;
          tok_col_d  = col_q;
          plen_d     = 8'd1;
        end
      end
      // Advance the position of the next byte.
      if (b == "\n") begin
        if (line_q != stt_pkg::MAX_LINE) begin
          line_d = line_q + 16'd1;
        end
        col_d = 16'd1;
      end else if (col_q != stt_pkg::MAX_COLUMN) begin
        col_d = col_q + 16'd1;
      end
    end

    // Pack the results in order and mark the last one.
    push_o = '0;
    if (v0 && v1) begin
      push_o.count  = 2'd2;
      push_o.first  = r0;
      push_o.second = r1;
      push_o.second.last_of_run = 1'b1;
    end else if (v0) begin
      push_o.count = 2'd1;
      push_o.first = r0;
      push_o.first.last_of_run = 1'b1;
    end else if (v1) begin
      push_o.count = 2'd1;
      push_o.first = r1;
      push_o.first.last_of_run = 1'b1;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= stt_pkg::MODE_IDLE;
      tok_line_q <= 16'd0;
      tok_col_q  <= 16'd0;
      plen_q     <= 8'd0;
      line_q     <= 16'd1;
      col_q      <= 16'd1;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      plen_q     <= plen_d;
      line_q     <= line_d;
      col_q      <= col_d;
    end
  end

endmodule

### rtl/stt_out_queue.sv
// Result queue: takes up to two tokens a cycle and hands out one a cycle while out_stall_i is low.
`timescale 1ns / 1ps

module stt_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_en_i,
  input  stt_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stt_pkg::out_t  out_data_o
);

  stt_pkg::out_t entry_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic [1:0] n_push;
  logic       pop;

  assign n_push      = push_en_i ? push_i.count : 2'd0;
  assign out_valid_o = (count_q != 3'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = entry_q[rd_ptr_q];
  // Room for the worst case of two tokens from one byte.
  assign room_o      = (count_q <= 3'd2);

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (n_push == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

endmodule

### rtl/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
`timescale 1ns / 1ps

// Streaming lexer that takes one source byte per cycle and returns tokens with
// their kind, start line and column, and length. A byte is scanned in the
// cycle it is taken; its tokens enter a four-entry result queue and appear on
// the output from the next cycle on, one token per cycle while out_stall_i is
// low. A byte that closes a pending token and is a token of its own produces
// two results, which leave the queue one after the other. The input stalls
// while the queue has fewer than two free entries, so the sustained rate is one
// byte per cycle as long as tokens are taken as fast as they are made. A NUL
// byte or end_of_input flushes the pending token, emits an end token and
// restarts at line 1, column 1.
module source_text_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  stt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output stt_pkg::out_t out_data_o
);

  logic           accept;
  logic           room;
  stt_pkg::push_t push;

  // An input transaction completes when valid meets free queue room.
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  stt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .push_o   (push)
  );

  stt_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (accept),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
